FILE: src/hrpd_pkg.sv
// Shared types and constants for the heart-rate peak detector.
package hrpd_pkg;

	localparam int DEF_AVERAGE_TAPS = 8;
	localparam int DEF_SAMPLE_BITS  = 12;

	localparam int RATE_W   = 10;
	localparam int OFFSET_W = 12;
	localparam int WORD_W   = 16;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [RATE_W-1:0]   SAMPLE_RATE_RESET      = 10'd480;
	localparam logic [OFFSET_W-1:0] THRESHOLD_OFFSET_RESET = 12'd100;
	localparam logic [WORD_W-1:0]   THRESHOLD_RESET        = 16'hFFFF;
	localparam logic [WORD_W-1:0]   INTERVAL_MAX           = 16'hFFFF;

	// Register index, taken from paddr[2].
	localparam logic REG_SAMPLE_RATE      = 1'b0;
	localparam logic REG_THRESHOLD_OFFSET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVERAGE,
		ST_UPDATE,
		ST_RATE_WAIT,
		ST_DONE
	} state_t;

	// Sequencer controls toward the datapath.
	typedef struct packed {
		logic sample_ready;
		logic div_start;
		logic update_en;
		logic out_load;
	} ctrl_t;

	// 60 * rate computed as (rate << 6) - (rate << 2).
	function automatic logic [WORD_W-1:0] per_minute(input logic [RATE_W-1:0] rate);
		logic [WORD_W-1:0] r;
		r = WORD_W'(rate);
		return (r << 6) - (r << 2);
	endfunction

endpackage

FILE: src/hrpd_avg.sv
// Moving-average window: tap shift line with a running sum.
module hrpd_avg #(
	parameter int TAPS = hrpd_pkg::DEF_AVERAGE_TAPS,
	parameter int SB   = hrpd_pkg::DEF_SAMPLE_BITS,
	localparam int SUM_W = SB + $clog2(TAPS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [SB-1:0]    sample,
	output logic [SUM_W-1:0] sum
);

	logic [SB-1:0]    taps_q [TAPS];
	logic [SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				taps_q[k] <= '0;
			end
			sum_q <= '0;
		end else if (push) begin
			for (int k = 0; k < TAPS - 1; k++) begin
				taps_q[k] <= taps_q[k+1];
			end
			taps_q[TAPS-1] <= sample;
			// drop the oldest tap, add the newest
			sum_q <= sum_q + SUM_W'(sample) - SUM_W'(taps_q[0]);
		end
	end

	assign sum = sum_q;

endmodule

FILE: src/hrpd_div.sv
// Restoring divider, one quotient bit per cycle.
module hrpd_div #(
	parameter int W = 16,
	localparam int CNT_W = $clog2(W + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quot_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       shifted;
	logic [W:0]       trial;
	logic             fits;

	assign shifted = {rem_q, quot_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[W-1:0] : shifted[W-1:0];
			quot_q <= {quot_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: src/heart_rate_peak_detector_unit.sv
// Heart-rate peak detector: averaging, adaptive threshold, beat and rate estimate.
// From a sample beat the result passes the averaging, update and done states, and the
// rate-wait state of the bit-serial divider that forms the rate when a beat fires.
// One sample at a time: the next is taken only once the result is loaded, later while
// a finished result still waits on result_ready (stall for as long).
// arst_n clears taps, window, threshold (65535), rate and registers to reset values.
module heart_rate_peak_detector_unit #(
	parameter int AVERAGE_TAPS = hrpd_pkg::DEF_AVERAGE_TAPS,
	parameter int SAMPLE_BITS  = hrpd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample channel
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic [SAMPLE_BITS-1:0]         raw_sample,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [SAMPLE_BITS-1:0]         filtered_sample,
	output logic [hrpd_pkg::WORD_W-1:0]    threshold,
	output logic [hrpd_pkg::WORD_W-1:0]    beats_per_minute,
	output logic                           beat_detected,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hrpd_pkg::ADDR_W-1:0]    paddr,
	input  logic [hrpd_pkg::DATA_W-1:0]    pwdata,
	output logic [hrpd_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);

	localparam int SUM_W = SAMPLE_BITS + $clog2(AVERAGE_TAPS);
	localparam int SB    = SAMPLE_BITS;
	localparam int RW    = hrpd_pkg::RATE_W;
	localparam int WW    = hrpd_pkg::WORD_W;

	// Division of the tap sum by the tap count as a multiply by a rounded-up
	// reciprocal; exact for every sum below 2**SUM_W.
	localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_TAPS);
	localparam int RECIP_W   = SUM_W + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(
		((64'd1 << AVG_SHIFT) + 64'(AVERAGE_TAPS) - 64'd1) / 64'(AVERAGE_TAPS));

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [RW-1:0]                 sample_rate_q;
	logic [hrpd_pkg::OFFSET_W-1:0] threshold_offset_q;
	logic                          cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q      <= hrpd_pkg::SAMPLE_RATE_RESET;
			threshold_offset_q <= hrpd_pkg::THRESHOLD_OFFSET_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				hrpd_pkg::REG_SAMPLE_RATE:      sample_rate_q      <= pwdata[RW-1:0];
				hrpd_pkg::REG_THRESHOLD_OFFSET: threshold_offset_q <= pwdata[hrpd_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			hrpd_pkg::REG_SAMPLE_RATE:      prdata = hrpd_pkg::DATA_W'(sample_rate_q);
			hrpd_pkg::REG_THRESHOLD_OFFSET: prdata = hrpd_pkg::DATA_W'(threshold_offset_q);
			default:                        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	hrpd_pkg::state_t state_q, state_d;
	hrpd_pkg::ctrl_t  ctrl;
	logic             div_done;
	logic             fire;
	logic             out_free;

	// The result register is free when empty or being drained this cycle.
	assign out_free = !result_valid || result_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hrpd_pkg::ST_IDLE:      if (sample_valid) state_d = hrpd_pkg::ST_AVERAGE;
			hrpd_pkg::ST_AVERAGE:   state_d = hrpd_pkg::ST_UPDATE;
			hrpd_pkg::ST_UPDATE:    state_d = fire ? hrpd_pkg::ST_RATE_WAIT : hrpd_pkg::ST_DONE;
			hrpd_pkg::ST_RATE_WAIT: if (div_done) state_d = hrpd_pkg::ST_DONE;
			hrpd_pkg::ST_DONE:      if (out_free) state_d = hrpd_pkg::ST_IDLE;
			default:                state_d = hrpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			hrpd_pkg::ST_IDLE:      ctrl.sample_ready = 1'b1;
			hrpd_pkg::ST_UPDATE: begin
				ctrl.update_en    = 1'b1;
				ctrl.div_start    = fire;
			end
			hrpd_pkg::ST_DONE:      ctrl.out_load     = out_free;
			default:                ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sample_ready = ctrl.sample_ready;

	// ---------------------------------------------------------------------
	// Averaging window and rate divider
	// ---------------------------------------------------------------------
	logic [SUM_W-1:0]  window_sum;
	logic [PROD_W-1:0] avg_prod;
	logic [SB-1:0]     avg_level;
	logic [WW-1:0]     div_dividend;
	logic [WW-1:0]     div_divisor;
	logic [WW-1:0]     div_quotient;
	logic [WW-1:0]     interval_inc;

	hrpd_avg #(
		.TAPS (AVERAGE_TAPS),
		.SB   (SAMPLE_BITS)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (sample_valid && ctrl.sample_ready),
		.sample (raw_sample),
		.sum    (window_sum)
	);

	assign avg_prod  = PROD_W'(window_sum) * PROD_W'(AVG_RECIP);
	assign avg_level = SB'(avg_prod >> AVG_SHIFT);

	// The rate divides 60 * sample_rate by the samples since the last beat.
	assign div_dividend = hrpd_pkg::per_minute(sample_rate_q);
	assign div_divisor  = interval_inc;

	hrpd_div #(
		.W (WW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// ---------------------------------------------------------------------
	// Threshold adaptation and beat detection state
	// ---------------------------------------------------------------------
	logic [SB-1:0] level_q;
	logic [RW-1:0] win_cnt_q;
	logic [SB-1:0] win_max_q;
	logic [SB-1:0] win_min_q;
	logic [WW-1:0] thr_q;
	logic [WW-1:0] interval_q;
	logic [SB-1:0] hist_q [3];
	logic          latched_q;
	logic          fire_q;
	logic [WW-1:0] rate_q;

	logic [RW:0]   cnt_inc;
	logic          in_window;
	logic [SB:0]   mid_sum;
	logic [WW-1:0] thr_adapt;
	logic [WW-1:0] thr_now;
	logic          above;

	assign cnt_inc   = {1'b0, win_cnt_q} + (RW + 1)'(1);
	assign in_window = cnt_inc < {1'b0, sample_rate_q};
	assign mid_sum   = {1'b0, win_max_q} + {1'b0, win_min_q};
	assign thr_adapt = WW'(mid_sum[SB:1]) + WW'(threshold_offset_q);

	// A threshold adapted at a window end already applies to this sample.
	assign thr_now = (!in_window && (win_max_q > win_min_q)) ? thr_adapt : thr_q;

	assign interval_inc = (interval_q != hrpd_pkg::INTERVAL_MAX)
		? interval_q + WW'(1) : interval_q;

	assign above = WW'(level_q) > thr_now;

	// Local maximum: middle point at or above the oldest, newest below it.
	assign fire = above && (hist_q[2] >= hist_q[1]) && (level_q < hist_q[2]) && !latched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q  <= '0;
			win_max_q  <= '0;
			win_min_q  <= '1;
			thr_q      <= hrpd_pkg::THRESHOLD_RESET;
			interval_q <= '0;
			for (int k = 0; k < 3; k++) begin
				hist_q[k] <= '0;
			end
			latched_q  <= 1'b0;
			fire_q     <= 1'b0;
			rate_q     <= '0;
		end else begin
			if (ctrl.update_en) begin
				// Track extremes inside the window; at its end adapt and restart.
				if (in_window) begin
					win_cnt_q <= cnt_inc[RW-1:0];
					if (level_q > win_max_q) win_max_q <= level_q;
					if (level_q < win_min_q) win_min_q <= level_q;
				end else begin
					win_cnt_q <= '0;
					win_max_q <= '0;
					win_min_q <= '1;
				end
				thr_q      <= thr_now;
				interval_q <= fire ? '0 : interval_inc;
				fire_q     <= fire;
				if (above) begin
					hist_q[0] <= hist_q[1];
					hist_q[1] <= hist_q[2];
					hist_q[2] <= level_q;
					if (fire) latched_q <= 1'b1;
				end else begin
					latched_q <= 1'b0;
				end
			end
			if (state_q == hrpd_pkg::ST_RATE_WAIT && div_done) begin
				rate_q <= div_quotient;
			end
		end
	end

	// Capture the filtered level in ST_AVERAGE, the cycle after the sample beat.
	always_ff @(posedge clk) begin
		if (state_q == hrpd_pkg::ST_AVERAGE) begin
			level_q <= avg_level;
		end
	end

	// ---------------------------------------------------------------------
	// Result register: holds the beat until taken, frees the sequencer
	// ---------------------------------------------------------------------
	logic          res_valid_q;
	logic [SB-1:0] res_level_q;
	logic [WW-1:0] res_thr_q;
	logic [WW-1:0] res_rate_q;
	logic          res_beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			res_level_q <= level_q;
			res_thr_q   <= thr_q;
			res_rate_q  <= rate_q;
			res_beat_q  <= fire_q;
		end
	end

	assign result_valid     = res_valid_q;
	assign filtered_sample  = res_level_q;
	assign threshold        = res_thr_q;
	assign beats_per_minute = res_rate_q;
	assign beat_detected    = res_beat_q;

endmodule
